// ===== rtl/rational_arithmetic_unit_defines.svh =====
// assertion macros shared by the rational arithmetic unit
// no dependencies
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define RAU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rau_pkg.sv =====
// types, operation codes and constants for the rational arithmetic unit
// no dependencies
package rau_pkg;

   localparam int WORD_BITS_DEFAULT = 32;
   localparam int FIELD_BITS = 32;

   typedef enum logic [2:0] {
      OP_REDUCE  = 3'd0,
      OP_ADD     = 3'd1,
      OP_SUB     = 3'd2,
      OP_MUL     = 3'd3,
      OP_DIV     = 3'd4,
      OP_EQUAL   = 3'd5,
      OP_LESS    = 3'd6,
      OP_GREATER = 3'd7
   } op_type;

   typedef struct packed {
      logic [2:0]        operation;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic signed [31:0] res_den;
      logic               compare_true;
      logic               zero_gcd_error;
   } rsp_type;

   // datapath commands
   typedef enum logic [3:0] {
      CMD_NONE    = 4'd0,
      CMD_LOAD    = 4'd1,  // latch item, start first product pair
      CMD_MUL2    = 4'd2,  // second product pair
      CMD_FORM    = 4'd3,  // form n/d and compare outcome
      CMD_GCD_INIT = 4'd4, // x = n, y = d
      CMD_DIV_START = 4'd5,
      CMD_DIV_STEP = 4'd6,
      CMD_GCD_NEXT = 4'd7, // x = y, y = remainder
      CMD_DIV_N   = 4'd8,  // start n / g
      CMD_SAVE_N  = 4'd9,  // keep quotient as reduced n, start d / g
      CMD_SAVE_D  = 4'd10, // keep quotient as reduced d
      CMD_ZERO_G  = 4'd11  // flag zero gcd
   } cmd_type;

   typedef struct packed {
      logic is_compare;
      logic x_zero;
      logic y_zero;
      logic div_done;
   } status_type;

endpackage

// ===== rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: one item (operation and two fractions) in, one result out.
// Arithmetic results are reduced by Euclid's gcd with truncated remainders, each
// remainder from a shared radix-2 divider; compares skip the gcd. One item is in
// flight at a time. A zero over zero pair comes back unreduced with zero_gcd_error
// set.
// depends on rau_pkg, rau_control, rau_datapath
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   rau_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rau_datapath #(.WORD_BITS(WORD_BITS)) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .result   (rsp_data)
   );

endmodule

// ===== rtl/rau_datapath.sv =====
// datapath: operand registers, one shared multiplier and a radix-2 divider
// depends on rau_pkg
module rau_datapath
   import rau_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    result
);

   localparam int CNT_BITS = $clog2(WORD_BITS + 1);

   typedef logic [WORD_BITS-1:0] word_type;

   function automatic word_type fit(input logic [31:0] v);
      word_type r;
      r = word_type'({{((WORD_BITS > 32) ? WORD_BITS - 32 : 1){v[31]}}, v});
      return r;
   endfunction

   // sign-extend or truncate a word back to the field width
   function automatic logic [FIELD_BITS-1:0] to_field(input word_type v);
      logic [63:0] w;
      w = 64'($signed(v));
      return w[FIELD_BITS-1:0];
   endfunction

   function automatic word_type magn(input word_type v);
      return v[WORD_BITS-1] ? word_type'(-v) : v;
   endfunction

   op_type   op_ff, op_in;
   word_type an_ff, ad_ff, bn_ff, bd_ff;
   word_type an_in, ad_in, bn_in, bd_in;
   word_type p1_ff, p2_ff, p1_in, p2_in;
   word_type x_ff, y_ff, x_in, y_in;
   word_type rn_ff, rd_ff, rn_in, rd_in;
   logic     cmp_ff, cmp_in, err_ff, err_in;

   // divider state: quotient shifts into dq, remainder in dr
   word_type dq_ff, dq_in, dr_ff, dr_in, dv_ff, dv_in;
   logic     dsq_ff, dsq_in, dsr_ff, dsr_in;
   logic [CNT_BITS-1:0] dcnt_ff, dcnt_in;

   word_type mul_a, mul_b, mul_p;
   word_type div_a, div_b;
   logic [WORD_BITS:0] trial;
   word_type q_signed, r_signed;

   assign mul_p = word_type'(mul_a * mul_b);
   assign trial = {dr_ff, dq_ff[WORD_BITS-1]} - {1'b0, dv_ff};
   assign q_signed = dsq_ff ? word_type'(-dq_ff) : dq_ff;
   assign r_signed = dsr_ff ? word_type'(-dr_ff) : dr_ff;

   always_comb begin
      mul_a = an_ff;
      mul_b = bd_ff;
      div_a = x_ff;
      div_b = y_ff;
      case (cmd)
         CMD_LOAD: begin
            mul_a = fit(req_data.a_num);
            mul_b = (req_data.operation == OP_MUL) ? fit(req_data.b_num)
                                                    : fit(req_data.b_den);
         end
         CMD_MUL2: begin
            case (op_ff)
               OP_MUL: begin mul_a = ad_ff; mul_b = bd_ff; end
               OP_DIV: begin mul_a = ad_ff; mul_b = bn_ff; end
               OP_REDUCE: begin mul_a = ad_ff; mul_b = bd_ff; end
               default: begin mul_a = bn_ff; mul_b = ad_ff; end
            endcase
         end
         // common denominator for add and sub
         CMD_FORM: begin mul_a = ad_ff; mul_b = bd_ff; end
         CMD_DIV_N: begin div_a = rn_ff; div_b = x_ff; end
         CMD_SAVE_N: begin div_a = rd_ff; div_b = x_ff; end
         default: begin
            mul_a = an_ff;
            mul_b = bd_ff;
         end
      endcase
   end

   always_comb begin
      op_in = op_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      p1_in = p1_ff; p2_in = p2_ff;
      x_in = x_ff; y_in = y_ff;
      rn_in = rn_ff; rd_in = rd_ff;
      cmp_in = cmp_ff; err_in = err_ff;
      dq_in = dq_ff; dr_in = dr_ff; dv_in = dv_ff;
      dsq_in = dsq_ff; dsr_in = dsr_ff; dcnt_in = dcnt_ff;
      case (cmd)
         CMD_LOAD: begin
            op_in = op_type'(req_data.operation);
            an_in = fit(req_data.a_num);
            ad_in = fit(req_data.a_den);
            bn_in = fit(req_data.b_num);
            bd_in = fit(req_data.b_den);
            p1_in = mul_p;
         end
         CMD_MUL2: p2_in = mul_p;
         CMD_FORM: begin
            cmp_in = 1'b0;
            err_in = 1'b0;
            case (op_ff)
               OP_REDUCE: begin rn_in = an_ff; rd_in = ad_ff; end
               OP_ADD: begin rn_in = word_type'(p1_ff + p2_ff); rd_in = mul_p; end
               OP_SUB: begin rn_in = word_type'(p1_ff - p2_ff); rd_in = mul_p; end
               OP_MUL, OP_DIV: begin rn_in = p1_ff; rd_in = p2_ff; end
               OP_EQUAL: begin
                  rn_in = '0; rd_in = '0;
                  cmp_in = (an_ff == bn_ff) && (ad_ff == bd_ff);
               end
               OP_LESS: begin
                  rn_in = '0; rd_in = '0;
                  cmp_in = $signed(p1_ff) < $signed(p2_ff);
               end
               default: begin
                  rn_in = '0; rd_in = '0;
                  cmp_in = $signed(p2_ff) < $signed(p1_ff);
               end
            endcase
         end
         CMD_GCD_INIT: begin x_in = rn_ff; y_in = rd_ff; end
         CMD_DIV_START, CMD_DIV_N, CMD_SAVE_N: begin
            dq_in = magn(div_a);
            dr_in = '0;
            dv_in = magn(div_b);
            dsq_in = div_a[WORD_BITS-1] ^ div_b[WORD_BITS-1];
            dsr_in = div_a[WORD_BITS-1];
            dcnt_in = CNT_BITS'(WORD_BITS);
            if (cmd == CMD_SAVE_N) rn_in = q_signed;
         end
         CMD_DIV_STEP: begin
            if (!trial[WORD_BITS]) begin
               dr_in = trial[WORD_BITS-1:0];
               dq_in = {dq_ff[WORD_BITS-2:0], 1'b1};
            end else begin
               dr_in = {dr_ff[WORD_BITS-2:0], dq_ff[WORD_BITS-1]};
               dq_in = {dq_ff[WORD_BITS-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 1'b1;
         end
         CMD_GCD_NEXT: begin x_in = y_ff; y_in = r_signed; end
         CMD_SAVE_D: rd_in = q_signed;
         CMD_ZERO_G: err_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      p1_ff <= p1_in; p2_ff <= p2_in;
      x_ff <= x_in; y_ff <= y_in;
      rn_ff <= rn_in; rd_ff <= rd_in;
      cmp_ff <= cmp_in; err_ff <= err_in;
      dq_ff <= dq_in; dr_ff <= dr_in; dv_ff <= dv_in;
      dsq_ff <= dsq_in; dsr_ff <= dsr_in;
      if (reset) begin
         dcnt_ff <= '0;
      end else begin
         dcnt_ff <= dcnt_in;
      end
   end

   assign status.is_compare = (op_ff == OP_EQUAL) || (op_ff == OP_LESS) ||
                              (op_ff == OP_GREATER);
   assign status.x_zero   = (x_ff == '0);
   assign status.y_zero   = (y_ff == '0);
   assign status.div_done = (dcnt_ff == '0);

   assign result.res_num = to_field(rn_ff);
   assign result.res_den = to_field(rd_ff);
   assign result.compare_true = cmp_ff;
   assign result.zero_gcd_error = err_ff;

endmodule

// ===== rtl/rau_control.sv =====
// sequencer for the rational arithmetic unit: handshake and datapath commands
// depends on rau_pkg and the assertion macro header
`include "rational_arithmetic_unit_defines.svh"
module rau_control
   import rau_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_MUL2    = 10'b0000000010,
      ST_FORM    = 10'b0000000100,
      ST_INIT    = 10'b0000001000,
      ST_TEST    = 10'b0000010000,
      ST_GDIV    = 10'b0000100000,
      ST_NDIV    = 10'b0001000000,
      ST_DDIV    = 10'b0010000000,
      ST_SAVE    = 10'b0100000000,
      ST_OUT     = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      cmd = CMD_NONE;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd = CMD_LOAD;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin cmd = CMD_MUL2; state_in = ST_FORM; end
         ST_FORM: begin cmd = CMD_FORM; state_in = ST_INIT; end
         ST_INIT: begin
            if (status.is_compare) begin
               state_in = ST_OUT;
            end else begin
               cmd = CMD_GCD_INIT;
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            // y is zero: x holds the gcd
            if (!status.y_zero) begin
               cmd = CMD_DIV_START;
               state_in = ST_GDIV;
            end else if (status.x_zero) begin
               // gcd zero only when n and d are both zero
               cmd = CMD_ZERO_G;
               state_in = ST_OUT;
            end else begin
               state_in = ST_NDIV;
            end
         end
         ST_GDIV: begin
            if (!status.div_done) begin
               cmd = CMD_DIV_STEP;
            end else begin
               cmd = CMD_GCD_NEXT;
               state_in = ST_TEST;
            end
         end
         ST_NDIV: begin
            cmd = CMD_DIV_N;
            state_in = ST_DDIV;
         end
         ST_DDIV: begin
            if (!status.div_done) begin
               cmd = CMD_DIV_STEP;
            end else begin
               cmd = CMD_SAVE_N;
               state_in = ST_SAVE;
            end
         end
         ST_SAVE: begin
            if (!status.div_done) begin
               cmd = CMD_DIV_STEP;
            end else begin
               cmd = CMD_SAVE_D;
               state_in = ST_OUT;
            end
         end
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `RAU_ASSERT_IMPLY(a_ready_only_idle, clock, reset, req_ready, !rsp_valid, "ready while result pending")
   `RAU_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, !req_ready, "accepted item did not start")
   `RAU_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped before taken")

endmodule
